FILE: rtl/core/kflt_pkg.sv
// ----------------------------------------------------------------------------
// kflt_pkg
// Shared types and constants of the keyframe position track.
// ----------------------------------------------------------------------------
package kflt_pkg;

    localparam int MAX_KEYS = 64;
    localparam int IDX_W    = $clog2(MAX_KEYS);
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);
    localparam int KEY_W    = 128;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_EVAL   = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    localparam logic [1:0] WRAP_LOOP = 2'd1;
    localparam logic [1:0] WRAP_PING = 2'd2;

    localparam logic CFG_PRE  = 1'b0;
    localparam logic CFG_POST = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INS_WR,
        ST_LEN_RD,
        ST_LEN_WT,
        ST_REM,
        ST_WRAP,
        ST_FIND_RD,
        ST_FIND_CMP,
        ST_PAIR_RD,
        ST_PAIR_WT,
        ST_DIV_GO,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } t_state;

endpackage

FILE: rtl/core/kflt_divider.sv
// ----------------------------------------------------------------------------
// kflt_divider
// Restoring unsigned divider, one quotient bit per cycle, with remainder.
// ----------------------------------------------------------------------------
module kflt_divider import kflt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_num,
    input  logic [33:0] i_den,
    output logic        o_done,
    output logic [47:0] o_quot,
    output logic [33:0] o_rem
);

    logic [47:0] r_quot;
    logic [34:0] r_rem;
    logic [33:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [34:0] n_try;
    logic [34:0] n_sh;

    // One shift and trial subtract per cycle.
    assign n_sh  = {r_rem[33:0], r_quot[47]};
    assign n_try = n_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd48;
                r_quot <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!n_try[34]) begin
                    r_rem <= n_try;
                end else begin
                    r_rem <= n_sh;
                end
                r_quot <= {r_quot[46:0], ~n_try[34]};
                r_cnt  <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem[33:0];

endmodule

FILE: rtl/core/keyframe_position_lerp_track_core.sv
// ----------------------------------------------------------------------------
// keyframe_position_lerp_track_core
// Sorted keyframe table in one synchronous RAM with linear evaluation.
// ----------------------------------------------------------------------------
// Insert: scans keys for the slot, then moves each later key up one place.
// Evaluate: length read, a remainder divide when the time wraps, a scan of up
// to 64 keys, a divide and a multiply step.
// Clear empties the table. One request at a time; busy is high until the strobe.
// Results cannot be stalled. Synchronous reset empties the table at once.
module keyframe_position_lerp_track_core import kflt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [1:0]         i_cfg_data,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_time_in,
    input  logic signed [31:0] i_val_x,
    input  logic signed [31:0] i_val_y,
    input  logic signed [31:0] i_val_z,
    output logic               o_strobe,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic               o_status
);

    // Key RAM: {time, x, y, z}.
    logic [KEY_W-1:0] r_mem [MAX_KEYS];
    logic [KEY_W-1:0] r_rd;
    logic [IDX_W-1:0] n_ra;
    logic [IDX_W-1:0] n_wa;
    logic [KEY_W-1:0] n_wd;
    logic             n_we;

    t_state r_state, n_state;
    logic [1:0]   r_pre, r_post;
    logic [CNT_W-1:0] r_cnt, r_pos;
    logic signed [31:0] r_t, r_vx, r_vy, r_vz;
    logic signed [33:0] r_len, r_w, r_rm;
    logic [KEY_W-1:0] r_ka;
    logic signed [31:0] r_ox, r_oy, r_oz;
    logic         r_status, r_strobe;
    logic [16:0]  r_f;

    logic         dv_start, dv_done;
    logic [47:0]  dv_num, dv_quot;
    logic [33:0]  dv_den, dv_rem;

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_wa] <= n_wd;
        end
        r_rd <= r_mem[n_ra];
    end

    kflt_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(dv_start),
        .i_num  (dv_num),
        .i_den  (dv_den),
        .o_done (dv_done),
        .o_quot (dv_quot),
        .o_rem  (dv_rem)
    );

    logic signed [33:0] rd_t;
    logic signed [33:0] abs_t;
    logic signed [33:0] two_len;
    logic signed [33:0] cur_len;
    logic               t_neg;
    assign rd_t    = 34'(signed'(r_rd[127:96]));
    assign t_neg   = r_t[31];
    assign abs_t   = t_neg ? -34'(r_t) : 34'(r_t);
    assign two_len = r_len <<< 1;
    // In ST_LEN_WT the length comes straight from the RAM output, before r_len holds it.
    assign cur_len = (r_state == ST_LEN_WT) ? ((rd_t < 0) ? '0 : rd_t) : r_len;
    logic use_ping, use_loop;
    assign use_loop = t_neg ? (r_pre == WRAP_LOOP) : (r_post == WRAP_LOOP);
    assign use_ping = t_neg ? (r_pre == WRAP_PING) : (r_post == WRAP_PING);

    // Divider operands: remainder of |t|, or blend numerator.
    always_comb begin
        dv_start = 1'b0;
        dv_num   = {14'd0, abs_t};
        dv_den   = use_ping ? (cur_len <<< 1) : cur_len;
        if (r_state == ST_LEN_WT && r_cnt >= CNT_W'(2)) begin
            dv_start = (cur_len > 0) && ((t_neg && (use_loop || use_ping)) ||
                       (!t_neg && 34'(r_t) > cur_len && (use_loop || use_ping)));
        end
        if (r_state == ST_DIV_GO) begin
            dv_start = 1'b1;
            dv_num   = 48'(r_w - 34'(signed'(r_ka[127:96]))) << 16;
            dv_den   = 34'(rd_t - 34'(signed'(r_ka[127:96])));
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (start) begin
                unique case (t_req'(i_req_type))
                    REQ_INSERT: n_state = (r_cnt >= CNT_W'(MAX_KEYS)) ? ST_DONE :
                                (r_cnt == '0) ? ST_INS_WR : ST_SRCH_RD;
                    REQ_EVAL:   n_state = ST_LEN_RD;
                    default:    n_state = ST_DONE;
                endcase
            end
            ST_SRCH_RD:  n_state = ST_SRCH_CMP;
            ST_SRCH_CMP: begin
                if (rd_t >= 34'(r_t)) n_state = (r_cnt == r_pos) ? ST_INS_WR
                                                                   : ST_SHIFT_RD;
                else if (r_pos + 1'b1 == r_cnt) n_state = ST_INS_WR;
                else n_state = ST_SRCH_RD;
            end
            ST_SHIFT_RD: n_state = ST_SHIFT_WR;
            ST_SHIFT_WR: n_state = (r_rm[CNT_W-1:0] == r_pos) ? ST_INS_WR : ST_SHIFT_RD;
            ST_INS_WR:   n_state = ST_DONE;
            ST_LEN_RD:   n_state = ST_LEN_WT;
            ST_LEN_WT:   n_state = (r_cnt < CNT_W'(2)) ? ST_DONE :
                                   dv_start ? ST_REM : ST_WRAP;
            ST_REM:      if (dv_done) n_state = ST_WRAP;
            ST_WRAP:     n_state = ST_FIND_RD;
            ST_FIND_RD:  n_state = ST_FIND_CMP;
            ST_FIND_CMP: begin
                if (rd_t >= r_w) n_state = (r_pos == '0) ? ST_DONE : ST_PAIR_RD;
                else if (r_pos + 1'b1 == r_cnt) n_state = ST_DONE;
                else n_state = ST_FIND_RD;
            end
            ST_PAIR_RD:  n_state = ST_PAIR_WT;
            ST_PAIR_WT:  n_state = ST_DIV_GO;
            ST_DIV_GO:   n_state = ST_DIV;
            ST_DIV:      if (dv_done) n_state = ST_MUL;
            ST_MUL:      n_state = ST_DONE;
            ST_DONE:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // RAM port control.
    always_comb begin
        n_ra = r_pos[IDX_W-1:0];
        n_we = 1'b0;
        n_wa = r_pos[IDX_W-1:0];
        n_wd = r_rd;
        unique case (r_state)
            ST_SHIFT_RD: n_ra = r_rm[IDX_W-1:0];
            ST_LEN_RD:   n_ra = IDX_W'(r_cnt - 1'b1);
            ST_PAIR_RD:  n_ra = IDX_W'(r_pos - 1'b1);
            ST_PAIR_WT:  n_ra = r_pos[IDX_W-1:0];
            default:     n_ra = r_pos[IDX_W-1:0];
        endcase
        if (r_state == ST_SHIFT_WR) begin
            n_we = 1'b1;
            n_wa = IDX_W'(r_rm[CNT_W-1:0] + 1'b1);
        end
        if (r_state == ST_INS_WR) begin
            n_we = 1'b1;
            n_wd = {r_t, r_vx, r_vy, r_vz};
        end
    end

    // Lerp of one lane from the registered blend factor.
    function automatic logic signed [31:0] lerp(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input logic [16:0] f);
        logic signed [33:0] d;
        logic signed [51:0] p;
        d = 34'(b) - 34'(a);
        p = d * $signed({1'b0, f});
        return 32'(34'(a) + 34'(p >>> 16));
    endfunction

    logic signed [33:0] c_rem;
    assign c_rem = 34'(dv_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_pre    <= '0;
            r_post   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_DONE);
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_PRE) r_pre <= i_cfg_data;
                else r_post <= i_cfg_data;
            end
            unique case (r_state)
                ST_IDLE: if (start) begin
                    r_t <= i_time_in; r_vx <= i_val_x;
                    r_vy <= i_val_y; r_vz <= i_val_z;
                    r_pos <= '0; r_status <= 1'b0;
                    r_ox <= '0; r_oy <= '0; r_oz <= '0;
                    if (t_req'(i_req_type) == REQ_CLEAR) r_cnt <= '0;
                    if (t_req'(i_req_type) == REQ_INSERT && r_cnt >= CNT_W'(MAX_KEYS))
                        r_status <= 1'b1;
                end
                ST_SRCH_CMP: begin
                    if (rd_t >= 34'(r_t)) r_rm <= 34'(r_cnt - 1'b1);
                    else r_pos <= r_pos + 1'b1;
                    if (rd_t < 34'(r_t) && r_pos + 1'b1 == r_cnt) r_pos <= r_cnt;
                end
                ST_SHIFT_RD: ;
                ST_SHIFT_WR: r_rm <= r_rm - 1'b1;
                ST_INS_WR: r_cnt <= r_cnt + 1'b1;
                ST_LEN_WT: begin
                    if (r_cnt == CNT_W'(1)) begin
                        r_ox <= r_rd[95:64]; r_oy <= r_rd[63:32]; r_oz <= r_rd[31:0];
                    end
                    r_len <= (rd_t < 0) ? '0 : rd_t;
                    r_ka  <= r_rd;
                end
                ST_WRAP: begin
                    if (r_len <= 0) r_w <= '0;
                    else if (t_neg) begin
                        if (use_loop) r_w <= r_len - c_rem;
                        else if (use_ping) r_w <= c_rem;
                        else r_w <= '0;
                    end else if (34'(r_t) > r_len) begin
                        if (use_loop) r_w <= c_rem;
                        else if (use_ping) r_w <= (c_rem > r_len) ? two_len - c_rem
                                                                   : c_rem;
                        else r_w <= r_len;
                    end else r_w <= 34'(r_t);
                end
                ST_FIND_CMP: begin
                    if (rd_t >= r_w) begin
                        if (r_pos == '0) begin
                            r_ox <= r_rd[95:64]; r_oy <= r_rd[63:32]; r_oz <= r_rd[31:0];
                        end
                    end else if (r_pos + 1'b1 == r_cnt) begin
                        r_ox <= r_ka[95:64]; r_oy <= r_ka[63:32]; r_oz <= r_ka[31:0];
                    end else r_pos <= r_pos + 1'b1;
                end
                ST_PAIR_WT: r_ka <= r_rd;
                ST_DIV: begin
                    r_f <= dv_quot[16:0];
                    if (!dv_done) r_vx <= r_vx;
                end
                ST_MUL: begin
                    r_ox <= lerp(r_ka[95:64], r_rd[95:64], r_f);
                    r_oy <= lerp(r_ka[63:32], r_rd[63:32], r_f);
                    r_oz <= lerp(r_ka[31:0], r_rd[31:0], r_f);
                end
                default: ;
            endcase
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_out_x  = r_ox;
    assign o_out_y  = r_oy;
    assign o_out_z  = r_oz;
    assign o_status = r_status;

    // A result beat follows only a finished request.
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == ST_DONE))
        else $error("strobe without finished request");
    // The key count never exceeds the table depth.
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_KEYS))
        else $error("key count overflow");
    // A rejected insert leaves the count unchanged.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status) |-> $stable(r_cnt))
        else $error("rejected insert changed the table");

endmodule

FILE: tb/sv/keyframe_position_lerp_track_core_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyframe_position_lerp_track_core_checker
// Watches the request and result beats of the keyframe track, keeps its own
// copy of the key table and wrap modes, predicts each result and compares it.
// ----------------------------------------------------------------------------
module keyframe_position_lerp_track_core_checker import kflt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [1:0]         i_cfg_data,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_time_in,
    input  logic signed [31:0] i_val_x,
    input  logic signed [31:0] i_val_y,
    input  logic signed [31:0] i_val_z,
    input  logic               o_strobe,
    input  logic signed [31:0] o_out_x,
    input  logic signed [31:0] o_out_y,
    input  logic signed [31:0] o_out_z,
    input  logic               o_status,
    output int                 o_fail_count,
    output int                 o_pending,
    output logic               o_beat
);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               status;
    } t_sample;

    longint     key_t [MAX_KEYS];
    longint     key_x [MAX_KEYS];
    longint     key_y [MAX_KEYS];
    longint     key_z [MAX_KEYS];
    int         num_keys;
    logic [1:0] pre_mode;
    logic [1:0] post_mode;
    t_sample    sample_queue[$];

    assign o_pending = sample_queue.size();
    assign o_beat    = (start && !busy) || o_strobe;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    function automatic longint floor_div_q16(input longint v);
        if (v >= 0) return v / 65536;
        return -((-v + 65535) / 65536);
    endfunction

    function automatic longint wrapped_time(input longint t, input longint len);
        longint two;
        longint c;
        two = 2 * len;
        if (len <= 0) return 0;
        if (t < 0) begin
            if (pre_mode == WRAP_LOOP) return len + (t % len);
            if (pre_mode == WRAP_PING) begin
                c = t % two;
                return c < 0 ? -c : c;
            end
            return 0;
        end
        if (t > len) begin
            if (post_mode == WRAP_LOOP) return t % len;
            if (post_mode == WRAP_PING) begin
                c = t % two;
                return c > len ? two - c : c;
            end
            return len;
        end
        return t;
    endfunction

    // Works out one result and updates the table copy.
    function automatic t_sample track_step(input logic [1:0] req, input longint t,
                                           input longint vx, input longint vy,
                                           input longint vz);
        t_sample s;
        longint len, w, f;
        int i, k, pos;
        s = '0;
        if (req == REQ_INSERT) begin
            if (num_keys >= MAX_KEYS) begin
                s.status = 1'b1;
            end else begin
                pos = 0;
                while (pos < num_keys && key_t[pos] < t) pos++;
                for (int j = num_keys; j > pos; j--) begin
                    key_t[j] = key_t[j-1];
                    key_x[j] = key_x[j-1];
                    key_y[j] = key_y[j-1];
                    key_z[j] = key_z[j-1];
                end
                key_t[pos] = t;
                key_x[pos] = vx;
                key_y[pos] = vy;
                key_z[pos] = vz;
                num_keys++;
            end
        end else if (req == REQ_EVAL && num_keys > 0) begin
            if (num_keys == 1) begin
                s.x = key_x[0];
                s.y = key_y[0];
                s.z = key_z[0];
            end else begin
                len = key_t[num_keys-1];
                if (len < 0) len = 0;
                w = wrapped_time(t, len);
                i = 0;
                while (i < num_keys && key_t[i] < w) i++;
                if (i == 0 || i == num_keys) begin
                    k = (i == 0) ? 0 : num_keys - 1;
                    s.x = key_x[k];
                    s.y = key_y[k];
                    s.z = key_z[k];
                end else begin
                    f = ((w - key_t[i-1]) * 65536) / (key_t[i] - key_t[i-1]);
                    s.x = key_x[i-1] + floor_div_q16((key_x[i] - key_x[i-1]) * f);
                    s.y = key_y[i-1] + floor_div_q16((key_y[i] - key_y[i-1]) * f);
                    s.z = key_z[i-1] + floor_div_q16((key_z[i] - key_z[i-1]) * f);
                end
            end
        end else if (req == REQ_CLEAR) begin
            num_keys = 0;
        end
        return s;
    endfunction

    // Sample both channels at the clock edge and compare results in order.
    always @(posedge i_clk) begin
        t_sample want;
        if (!i_rst_n) begin
            num_keys     = 0;
            pre_mode     = 2'd0;
            post_mode    = 2'd0;
            o_fail_count = 0;
            sample_queue.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_PRE) pre_mode = i_cfg_data;
                else post_mode = i_cfg_data;
            end
            if (o_strobe) begin
                if (sample_queue.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = sample_queue.pop_front();
                    if (o_out_x !== want.x) report_mismatch("out_x", o_out_x, want.x);
                    if (o_out_y !== want.y) report_mismatch("out_y", o_out_y, want.y);
                    if (o_out_z !== want.z) report_mismatch("out_z", o_out_z, want.z);
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                end
            end
            if (start && !busy)
                sample_queue.insert(sample_queue.size(),
                                    track_step(i_req_type, i_time_in, i_val_x,
                                               i_val_y, i_val_z));
        end
    end

endmodule

FILE: tb/sv/keyframe_position_lerp_track_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyframe_position_lerp_track_core_test
// Drives directed and random insert, evaluate and clear requests under all
// wrap mode settings and idle patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module keyframe_position_lerp_track_core_test;
    import kflt_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [1:0]         i_cfg_data;
    logic [1:0]         i_req_type;
    logic signed [31:0] i_time_in;
    logic signed [31:0] i_val_x;
    logic signed [31:0] i_val_y;
    logic signed [31:0] i_val_z;
    logic               o_strobe;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic signed [31:0] o_out_z;
    logic               o_status;
    int                 fail_count;
    int                 pending;
    logic               beat;
    int                 idle_pct;
    int                 quiet_cycles;

    keyframe_position_lerp_track_core dut (.*);

    keyframe_position_lerp_track_core_checker checker_u (
        .i_clk, .i_rst_n, .start, .busy, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_req_type, .i_time_in, .i_val_x, .i_val_y, .i_val_z, .o_strobe,
        .o_out_x, .o_out_y, .o_out_z, .o_status,
        .o_fail_count(fail_count), .o_pending(pending), .o_beat(beat)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog on cycles without any beat.
    always @(posedge i_clk) begin
        if (beat || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("keyframe_position_lerp_track_core_test: FAIL");
                $finish;
            end
        end
    end

    // Sends one request beat, with random idle cycles before it.
    task automatic send_request(input logic [1:0] req, input logic [31:0] t,
                                input logic [31:0] vx, input logic [31:0] vy,
                                input logic [31:0] vz);
        while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        i_req_type <= req;
        i_time_in  <= t;
        i_val_x    <= vx;
        i_val_y    <= vy;
        i_val_z    <= vz;
        start      <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_modes(input logic [1:0] pre, input logic [1:0] post);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_PRE;
        i_cfg_data <= pre;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_POST;
        i_cfg_data <= post;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_time();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $urandom_range(65536 * 8);
            2: return -$urandom_range(65536 * 8);
            3: return $urandom_range(40) * 32'h4000;
            4: return {$urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000};
            default: return $urandom_range(65536 * 40) - 65536 * 4;
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return $urandom_range(65536 * 64) - 65536 * 32;
        endcase
    endfunction

    // A track of random keys followed by queries, sometimes overfilled.
    task automatic random_track(input int n_items);
        int nk;
        int sent;
        sent = 0;
        while (sent < n_items) begin
            nk = ($urandom_range(9) == 0) ? 66 : $urandom_range(8);
            send_request(REQ_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
            repeat (nk) send_request(REQ_INSERT, pick_time(), pick_value(),
                                     pick_value(), pick_value());
            repeat ($urandom_range(12, 4)) begin
                send_request($urandom_range(9) == 0 ? 2'($urandom_range(3)) : REQ_EVAL,
                             pick_time(), $urandom(), $urandom(), $urandom());
            end
            sent += nk + 9;
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_PRE;
        i_cfg_data <= 2'd0;
        i_req_type <= REQ_INSERT;
        i_time_in  <= '0;
        i_val_x    <= '0;
        i_val_y    <= '0;
        i_val_z    <= '0;
        idle_pct   = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, single key, bracket and extreme times.
        send_request(REQ_EVAL, 32'h0001_0000, 0, 0, 0);
        send_request(REQ_INSERT, 32'h0002_0000, 32'h7FFFFFFF, 32'h80000000, 32'h1);
        send_request(REQ_EVAL, 32'h80000000, 0, 0, 0);
        send_request(REQ_INSERT, 32'h0, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
        send_request(REQ_INSERT, 32'h0002_0000, 32'h10, 32'h20, 32'h30);
        send_request(REQ_EVAL, 32'h0001_0000, 0, 0, 0);
        send_request(REQ_EVAL, 32'h7FFFFFFF, 0, 0, 0);
        send_request(REQ_EVAL, 32'h80000000, 0, 0, 0);
        send_request(REQ_EVAL, 32'h0, 0, 0, 0);
        send_request(REQ_NONE, 32'h1234, 1, 2, 3);
        write_modes(WRAP_LOOP, WRAP_LOOP);
        send_request(REQ_EVAL, 32'hFFFF_8000, 0, 0, 0);
        send_request(REQ_EVAL, 32'h0005_4000, 0, 0, 0);
        write_modes(WRAP_PING, WRAP_PING);
        send_request(REQ_EVAL, 32'hFFFD_0000, 0, 0, 0);
        send_request(REQ_EVAL, 32'h0003_0000, 0, 0, 0);
        write_modes(2'd3, 2'd3);
        send_request(REQ_EVAL, 32'hFFFD_0000, 0, 0, 0);
        send_request(REQ_EVAL, 32'h0009_0000, 0, 0, 0);
        // Track length not positive.
        send_request(REQ_CLEAR, 0, 0, 0, 0);
        send_request(REQ_INSERT, 32'hFFFE_0000, 5, 6, 7);
        send_request(REQ_INSERT, 32'hFFFF_0000, 8, 9, 10);
        send_request(REQ_EVAL, 32'h0004_0000, 0, 0, 0);

        // Random phases across idle patterns and mode settings.
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 55;
                2: idle_pct = 0;
                default: idle_pct = 33;
            endcase
            write_modes(2'(ph % 3), 2'((ph / 3) % 3));
            random_track(42);
            if (ph == 5) drain_results();
        end

        drain_results();
        if (fail_count == 0) begin
            $display("keyframe_position_lerp_track_core_test: PASS");
        end else begin
            $display("keyframe_position_lerp_track_core_test: FAIL");
        end
        $finish;
    end

endmodule
